/* hw/rtl/psu_pkg.sv */
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, codes and the predictor function of the scanline unfilter.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

    // Filter type codes as carried by the first byte of every row.
    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4
    } t_filter;

    localparam logic [7:0] FLT_LAST_CODE = 8'd4;

    // Configuration register indexes.
    localparam logic REG_ROW_BYTES   = 1'b0;
    localparam logic REG_PIXEL_BYTES = 1'b1;

    localparam int ROW_CFG_W  = 14;
    localparam int PIX_CFG_W  = 4;
    localparam int PIX_IDX_W  = 3;

    // One beat held between the control stage and the reconstruction stage.
    typedef struct packed {
        logic                 bad;
        logic [7:0]           data;
        t_filter              filter;
        logic                 first_row;
        logic                 left_ok;
        logic                 row_end;
        logic [PIX_IDX_W-1:0] pix_m1;
    } t_item;

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] sa;
        logic signed [9:0] sb;
        logic signed [9:0] sc;
        logic signed [9:0] pa;
        logic signed [9:0] pb;
        logic signed [9:0] pc;
        sa = $signed({2'b00, a});
        sb = $signed({2'b00, b});
        sc = $signed({2'b00, c});
        pa = sb - sc;
        pb = sa - sc;
        pc = sa + sb - sc - sc;
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end
        return c;
    endfunction

    function automatic logic [7:0] predict(input t_filter f, input logic [7:0] a,
                                           input logic [7:0] b, input logic [7:0] c);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        case (f)
            FLT_SUB:   return a;
            FLT_UP:    return b;
            FLT_AVG:   return sum[8:1];
            FLT_PAETH: return paeth(a, b, c);
            default:   return 8'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/psu_ram.sv */
// ----------------------------------------------------------------------------
// psu_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/psu_ctrl.sv */
// ----------------------------------------------------------------------------
// psu_ctrl
// Row sequencing: configuration registers, byte position, filter type and
// error hold. Decodes each input beat and issues the line store read.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_ctrl #(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_index,
    input  wire logic [psu_pkg::ROW_CFG_W-1:0]    i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [7:0]                       i_data_byte,
    input  wire logic                             i_image_start,
    input  wire logic                             i_pop,
    output logic                                  o_item_valid,
    output psu_pkg::t_item                        o_item,
    output logic [$clog2(MAX_ROW_BYTES)-1:0]      o_item_x,
    output logic                                  o_rd_en,
    output logic [$clog2(MAX_ROW_BYTES)-1:0]      o_rd_addr
);

    localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
    localparam int POS_W  = $clog2(MAX_ROW_BYTES + 1);
    localparam int CW     = (POS_W > psu_pkg::ROW_CFG_W) ? POS_W : psu_pkg::ROW_CFG_W;

    logic [psu_pkg::ROW_CFG_W-1:0] r_row_bytes;
    logic [psu_pkg::PIX_CFG_W-1:0] r_pixel_bytes;
    logic [POS_W-1:0]              r_pos;
    psu_pkg::t_filter              r_filter;
    logic                          r_first;
    logic                          r_err;
    logic                          r_s1_valid;
    psu_pkg::t_item                r_item;
    logic [ADDR_W-1:0]             r_x;

    logic [POS_W-1:0]              n_pos;
    psu_pkg::t_filter              n_filter;
    logic                          n_first;
    logic                          n_err;
    psu_pkg::t_item                n_item;
    logic [ADDR_W-1:0]             n_x;

    logic                          accept;
    logic                          load;
    logic [POS_W-1:0]              pos_e;
    logic [CW-1:0]                 rb_eff;
    logic [psu_pkg::PIX_CFG_W-1:0] pb_eff;

    assign o_in_stall = r_s1_valid && !i_pop;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_row_bytes == '0) begin
            rb_eff = CW'(1);
        end else if (CW'(r_row_bytes) > CW'(MAX_ROW_BYTES)) begin
            rb_eff = CW'(MAX_ROW_BYTES);
        end else begin
            rb_eff = CW'(r_row_bytes);
        end
        if (r_pixel_bytes == '0) begin
            pb_eff = psu_pkg::PIX_CFG_W'(1);
        end else if (r_pixel_bytes > psu_pkg::PIX_CFG_W'(MAX_PIXEL_BYTES)) begin
            pb_eff = psu_pkg::PIX_CFG_W'(MAX_PIXEL_BYTES);
        end else begin
            pb_eff = r_pixel_bytes;
        end
    end

    // An image start resets the row state before the beat is decoded.
    always_comb begin
        pos_e    = i_image_start ? '0 : r_pos;
        n_pos    = pos_e;
        n_filter = r_filter;
        n_first  = i_image_start ? 1'b1 : r_first;
        n_err    = i_image_start ? 1'b0 : r_err;
        load     = 1'b0;
        n_x      = ADDR_W'(pos_e - POS_W'(1));
        n_item.bad       = 1'b0;
        n_item.data      = i_data_byte;
        n_item.filter    = r_filter;
        n_item.first_row = n_first;
        n_item.left_ok   = CW'(n_x) >= CW'(pb_eff);
        n_item.row_end   = (CW'(n_x) + CW'(1)) >= rb_eff;
        n_item.pix_m1    = psu_pkg::PIX_IDX_W'(pb_eff - psu_pkg::PIX_CFG_W'(1));
        if (n_err) begin
            // Bytes are dropped until the next image start.
        end else if (pos_e == '0) begin
            if (i_data_byte > psu_pkg::FLT_LAST_CODE) begin
                n_err      = 1'b1;
                load       = 1'b1;
                n_item.bad = 1'b1;
            end else begin
                n_filter = psu_pkg::t_filter'(i_data_byte[2:0]);
                n_pos    = POS_W'(1);
            end
        end else begin
            load = 1'b1;
            if (n_item.row_end) begin
                n_pos   = '0;
                n_first = 1'b0;
            end else begin
                n_pos = POS_W'(n_x) + POS_W'(2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes   <= psu_pkg::ROW_CFG_W'(1);
            r_pixel_bytes <= psu_pkg::PIX_CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                psu_pkg::REG_ROW_BYTES:   r_row_bytes   <= i_cfg_data;
                psu_pkg::REG_PIXEL_BYTES: r_pixel_bytes <= i_cfg_data[psu_pkg::PIX_CFG_W-1:0];
                default:                  r_row_bytes   <= r_row_bytes;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_filter   <= psu_pkg::FLT_NONE;
            r_first    <= 1'b1;
            r_err      <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos    <= n_pos;
                r_filter <= n_filter;
                r_first  <= n_first;
                r_err    <= n_err;
            end
            if (accept && load) begin
                r_s1_valid <= 1'b1;
            end else if (i_pop) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && load) begin
            r_item <= n_item;
            r_x    <= n_x;
        end
    end

    assign o_item_valid = r_s1_valid;
    assign o_item       = r_item;
    assign o_item_x     = r_x;
    assign o_rd_en      = accept && load && !n_item.bad;
    assign o_rd_addr    = n_x;

endmodule

`default_nettype wire

/* hw/rtl/psu_recon.sv */
// ----------------------------------------------------------------------------
// psu_recon
// Byte reconstruction: neighbor selection, predictor, pixel history and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_recon #(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_item_valid,
    input  wire psu_pkg::t_item                   i_item,
    input  wire logic [$clog2(MAX_ROW_BYTES)-1:0] i_item_x,
    input  wire logic [7:0]                       i_above,
    output logic                                  o_pop,
    output logic                                  o_wr_en,
    output logic [$clog2(MAX_ROW_BYTES)-1:0]      o_wr_addr,
    output logic [7:0]                            o_wr_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [7:0]                            o_pixel_byte,
    output logic                                  o_row_end,
    output logic                                  o_bad_filter
);

    logic [7:0] r_left  [MAX_PIXEL_BYTES];
    logic [7:0] r_upper [MAX_PIXEL_BYTES];
    logic       r_out_valid;
    logic [7:0] r_pixel_byte;
    logic       r_row_end;
    logic       r_bad_filter;

    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] recon;

    assign o_pop = i_item_valid && (!r_out_valid || !i_out_stall);

    // The history is a shift line, newest byte first; one pixel back is
    // entry pixel_bytes - 1.
    always_comb begin
        a = 8'd0;
        c = 8'd0;
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            if (i_item.left_ok && i_item.pix_m1 == psu_pkg::PIX_IDX_W'(i)) begin
                a = r_left[i];
                c = r_upper[i];
            end
        end
        b     = i_item.first_row ? 8'd0 : i_above;
        recon = i_item.data + psu_pkg::predict(i_item.filter, a, b, c);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_item.bad) begin
            r_left[0]  <= recon;
            r_upper[0] <= b;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]  <= r_left[i-1];
                r_upper[i] <= r_upper[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pixel_byte <= i_item.bad ? 8'd0 : recon;
            r_row_end    <= !i_item.bad && i_item.row_end;
            r_bad_filter <= i_item.bad;
        end
    end

    assign o_wr_en      = o_pop && !i_item.bad;
    assign o_wr_addr    = i_item_x;
    assign o_wr_data    = recon;
    assign o_out_valid  = r_out_valid;
    assign o_pixel_byte = r_pixel_byte;
    assign o_row_end    = r_row_end;
    assign o_bad_filter = r_bad_filter;

endmodule

`default_nettype wire

/* hw/rtl/png_scanline_unfilter.sv */
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG filter reconstruction (None, Sub, Up, Average, Paeth) on an inflated
// byte stream, one byte per beat, with a previous-row line store.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  in        sink       i_in_valid / o_in_stall    i_data_byte, i_image_start
//  out       source     o_out_valid / i_out_stall  o_pixel_byte, o_row_end,
//                                                  o_bad_filter
//  cfg       sink       i_cfg_we                   i_cfg_index, i_cfg_data
//
// One input beat per cycle unless o_in_stall is high; a sample is decoded and its
// line store read issued at the accepting edge, then popped into the output register.
// The line store has one write and one registered read port.
// Synchronous active-low reset clears control state; the line store is not
// cleared, the first row of an image reads the row above as zero.
// A stall on the output holds the result register and backs up into o_in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [psu_pkg::ROW_CFG_W-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_image_start,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [7:0]                         o_pixel_byte,
    output logic                               o_row_end,
    output logic                               o_bad_filter
);

    localparam int ADDR_W = $clog2(MAX_ROW_BYTES);

    logic              pop;
    logic              item_valid;
    psu_pkg::t_item    item;
    logic [ADDR_W-1:0] item_x;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    psu_ctrl #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_image_start (i_image_start),
        .i_pop         (pop),
        .o_item_valid  (item_valid),
        .o_item        (item),
        .o_item_x      (item_x),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr)
    );

    psu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    psu_recon #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_recon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .i_item_x     (item_x),
        .i_above      (rd_data),
        .o_pop        (pop),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_byte (o_pixel_byte),
        .o_row_end    (o_row_end),
        .o_bad_filter (o_bad_filter)
    );

endmodule

`default_nettype wire
